>>> rtl/ggrm_pkg.sv
`timescale 1ns / 1ps

package ggrm_pkg;

  localparam int COLS        = 64;
  localparam int ROWS        = 64;
  localparam int ROW_ADDR_W  = 6;
  localparam int COL_IDX_W   = 6;
  localparam int LANE_BITS   = 8;
  localparam int LANES       = COLS / LANE_BITS;
  localparam int LANE_IDX_W  = 3;
  localparam int SUB_IDX_W   = 3;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_NEXT    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_BOX      = 2'd1,
    ST_DONE     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_LIMIT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RUN,
    S_DOWN_RD,
    S_DOWN_CHK,
    S_FINISH,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic                 any;
    logic [SUB_IDX_W-1:0] idx;
  } lane_res_t;

endpackage

>>> rtl/ggrm_ram.sv
`timescale 1ns / 1ps

module ggrm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/ggrm_lane.sv
`timescale 1ns / 1ps

module ggrm_lane import ggrm_pkg::*; (
  input  logic [LANE_BITS-1:0] bits,
  output lane_res_t            res
);

  always_comb begin
    res.any = |bits;
    res.idx = '0;
    for (int i = LANE_BITS - 1; i >= 0; i--) begin
      if (bits[i]) begin
        res.idx = SUB_IDX_W'(i);
      end
    end
  end

endmodule

>>> rtl/ggrm_merge.sv
`timescale 1ns / 1ps

module ggrm_merge import ggrm_pkg::*; (
  input  lane_res_t [LANES-1:0]  lanes,
  output logic                   any,
  output logic [COL_IDX_W-1:0]   pos
);

  always_comb begin
    any = 1'b0;
    pos = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (lanes[i].any) begin
        any = 1'b1;
        pos = {LANE_IDX_W'(i), lanes[i].idx};
      end
    end
  end

endmodule

>>> rtl/greedy_grid_rectangle_merge.sv
// Row load, restart and unknown opcodes: the item goes to S_EMIT, which loads the output
// register once it is free and returns to idle, where the next item can be taken.
// Box request: S_SCAN_RD and S_SCAN_CHK per scan row (S_SCAN_RD alone for a row with the
// scan column past the width), S_RUN, S_DOWN_RD and S_DOWN_CHK per row below the run,
// then S_FINISH and S_EMIT; a done answer: S_SCAN_RD, S_EMIT; the searches share one bank
// of eight 8-bit lanes. Reset is synchronous; used marks clear at once by per-row valid bits.
`timescale 1ns / 1ps

module greedy_grid_rectangle_merge import ggrm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [5:0]  row_index,
  input  logic [63:0] row_cells,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  box_x,
  output logic [5:0]  box_y,
  output logic [6:0]  box_w,
  output logic [6:0]  box_h,
  output logic [11:0] box_number,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  function automatic logic [COLS-1:0] low_mask(input logic [6:0] n);
    if (n[6]) begin
      return '1;
    end
    return (COLS'(1) << n[5:0]) - COLS'(1);
  endfunction

  state_t state, state_next;

  logic [6:0]  grid_width, grid_height;
  logic [12:0] box_limit;
  logic [6:0]  scan_row, scan_row_next;
  logic [5:0]  scan_col, scan_col_next;
  logic [12:0] boxes, boxes_next;
  logic [63:0] avail, avail_next;
  logic [5:0]  x, x_next;
  logic [63:0] used_top, used_top_next;
  logic [63:0] seg, seg_next;
  logic [6:0]  run_end, run_end_next;
  logic [6:0]  run_h, run_h_next;
  logic [6:0]  cur_row, cur_row_next;

  logic [1:0]  res_status, res_status_next;
  logic [5:0]  res_x, res_x_next, res_y, res_y_next;
  logic [6:0]  res_w, res_w_next, res_h, res_h_next;
  logic [11:0] res_num, res_num_next;

  logic        out_valid_next;
  logic [1:0]  status_next;
  logic [5:0]  box_x_next, box_y_next;
  logic [6:0]  box_w_next, box_h_next;
  logic [11:0] box_number_next;

  logic [ROWS-1:0] used_valid;
  logic            used_vld_rd;

  logic                  rd_en;
  logic [ROW_ADDR_W-1:0] rd_addr;
  logic                  solid_we, used_we;
  logic [ROW_ADDR_W-1:0] used_waddr;
  logic [63:0]           used_wdata;
  logic [63:0]           solid_q, used_q, used_eff;

  logic [6:0]  eff_w, eff_h;
  logic [63:0] wmask, free_row, lane_in, seg_c;
  logic [6:0]  end_c;

  lane_res_t [LANES-1:0] lane_res;
  logic                  m_any;
  logic [COL_IDX_W-1:0]  m_pos;

  logic in_take, out_free;

  assign eff_w    = (grid_width > 7'(COLS)) ? 7'(COLS) : grid_width;
  assign eff_h    = (grid_height > 7'(ROWS)) ? 7'(ROWS) : grid_height;
  assign wmask    = low_mask(eff_w);
  assign used_eff = used_vld_rd ? used_q : '0;
  assign free_row = solid_q & ~used_eff & wmask;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  ggrm_ram #(.DEPTH(ROWS), .WIDTH(COLS)) u_solid (
    .clk   (clk),
    .we    (solid_we),
    .waddr (row_index),
    .wdata (row_cells),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (solid_q)
  );

  ggrm_ram #(.DEPTH(ROWS), .WIDTH(COLS)) u_used (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (used_q)
  );

  assign lane_in = (state == S_RUN) ? (~avail & ~low_mask({1'b0, x}))
                                    : (free_row & ~low_mask({1'b0, scan_col}));

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ggrm_lane u_lane (
      .bits (lane_in[g*LANE_BITS +: LANE_BITS]),
      .res  (lane_res[g])
    );
  end

  ggrm_merge u_merge (
    .lanes (lane_res),
    .any   (m_any),
    .pos   (m_pos)
  );

  assign end_c = m_any ? {1'b0, m_pos} : 7'(COLS);
  assign seg_c = ~low_mask({1'b0, x}) & low_mask(end_c);

  always_comb begin
    state_next      = state;
    scan_row_next   = scan_row;
    scan_col_next   = scan_col;
    boxes_next      = boxes;
    avail_next      = avail;
    x_next          = x;
    used_top_next   = used_top;
    seg_next        = seg;
    run_end_next    = run_end;
    run_h_next      = run_h;
    cur_row_next    = cur_row;
    res_status_next = res_status;
    res_x_next      = res_x;
    res_y_next      = res_y;
    res_w_next      = res_w;
    res_h_next      = res_h;
    res_num_next    = res_num;
    out_valid_next  = out_valid && out_stall;
    status_next     = status;
    box_x_next      = box_x;
    box_y_next      = box_y;
    box_w_next      = box_w;
    box_h_next      = box_h;
    box_number_next = box_number;
    rd_en           = 1'b0;
    rd_addr         = scan_row[ROW_ADDR_W-1:0];
    solid_we        = 1'b0;
    used_we         = 1'b0;
    used_waddr      = scan_row[ROW_ADDR_W-1:0];
    used_wdata      = used_top | seg_c;

    case (state)
      S_IDLE: begin
        if (in_take) begin
          res_status_next = ST_ACCEPTED;
          res_x_next      = '0;
          res_y_next      = '0;
          res_w_next      = '0;
          res_h_next      = '0;
          res_num_next    = '0;
          state_next      = S_EMIT;
          case (opcode)
            OP_LOAD: begin
              solid_we = 1'b1;
            end
            OP_RESTART: begin
              scan_row_next = '0;
              scan_col_next = '0;
              boxes_next    = '0;
            end
            OP_NEXT: begin
              state_next = S_SCAN_RD;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        if (scan_row >= eff_h) begin
          res_status_next = ST_DONE;
          state_next      = S_EMIT;
        end else if ({1'b0, scan_col} >= eff_w) begin
          scan_row_next = scan_row + 7'd1;
          scan_col_next = '0;
        end else begin
          rd_en      = 1'b1;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (!m_any) begin
          scan_row_next = scan_row + 7'd1;
          scan_col_next = '0;
          state_next    = S_SCAN_RD;
        end else begin
          avail_next    = lane_in;
          x_next        = m_pos;
          used_top_next = used_eff;
          state_next    = S_RUN;
        end
      end
      S_RUN: begin
        used_we      = 1'b1;
        seg_next     = seg_c;
        run_end_next = end_c;
        run_h_next   = 7'd1;
        cur_row_next = scan_row + 7'd1;
        state_next   = S_DOWN_RD;
      end
      S_DOWN_RD: begin
        if (cur_row < eff_h) begin
          rd_en      = 1'b1;
          rd_addr    = cur_row[ROW_ADDR_W-1:0];
          state_next = S_DOWN_CHK;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DOWN_CHK: begin
        if ((free_row & seg) == seg) begin
          used_we      = 1'b1;
          used_waddr   = cur_row[ROW_ADDR_W-1:0];
          used_wdata   = used_eff | seg;
          run_h_next   = run_h + 7'd1;
          cur_row_next = cur_row + 7'd1;
          state_next   = S_DOWN_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (run_end >= eff_w) begin
          scan_row_next = scan_row + 7'd1;
          scan_col_next = '0;
        end else begin
          scan_col_next = run_end[5:0];
        end
        if (boxes >= box_limit) begin
          res_status_next = ST_OVERFLOW;
        end else begin
          res_status_next = ST_BOX;
          res_x_next      = x;
          res_y_next      = scan_row[5:0];
          res_w_next      = run_end - {1'b0, x};
          res_h_next      = run_h;
          res_num_next    = boxes[11:0];
          boxes_next      = boxes + 13'd1;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          status_next     = res_status;
          box_x_next      = res_x;
          box_y_next      = res_y;
          box_w_next      = res_w;
          box_h_next      = res_h;
          box_number_next = res_num;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      scan_row    <= '0;
      scan_col    <= '0;
      boxes       <= '0;
      out_valid   <= 1'b0;
      used_valid  <= '0;
      grid_width  <= 7'd64;
      grid_height <= 7'd64;
      box_limit   <= 13'd4096;
    end else begin
      state     <= state_next;
      scan_row  <= scan_row_next;
      scan_col  <= scan_col_next;
      boxes     <= boxes_next;
      out_valid <= out_valid_next;
      if (in_take && opcode == OP_RESTART) begin
        used_valid <= '0;
      end else if (used_we) begin
        used_valid[used_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  grid_width  <= cfg_data[6:0];
          CFG_HEIGHT: grid_height <= cfg_data[6:0];
          CFG_LIMIT:  box_limit   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      used_vld_rd <= used_valid[rd_addr];
    end
    avail      <= avail_next;
    x          <= x_next;
    used_top   <= used_top_next;
    seg        <= seg_next;
    run_end    <= run_end_next;
    run_h      <= run_h_next;
    cur_row    <= cur_row_next;
    res_status <= res_status_next;
    res_x      <= res_x_next;
    res_y      <= res_y_next;
    res_w      <= res_w_next;
    res_h      <= res_h_next;
    res_num    <= res_num_next;
    status     <= status_next;
    box_x      <= box_x_next;
    box_y      <= box_y_next;
    box_w      <= box_w_next;
    box_h      <= box_h_next;
    box_number <= box_number_next;
  end

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_BOX) |->
      (box_x == 6'd0 && box_y == 6'd0 && box_w == 7'd0 && box_h == 7'd0
       && box_number == 12'd0))
    else $error("result without a box carries non-zero box fields");

  a_box_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_BOX) |->
      (box_w != 7'd0 && box_h != 7'd0 && ({1'b0, box_x} + box_w) <= 7'd64
       && ({1'b0, box_y} + box_h) <= 7'd64))
    else $error("emitted box is empty or leaves the grid");

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state != S_IDLE))
    else $error("item taken but the sequencer stayed idle");

  a_used_write_busy: assert property (@(posedge clk) disable iff (rst)
    used_we |-> (state == S_RUN || state == S_DOWN_CHK))
    else $error("used marks written outside a box search");

endmodule
